// ===== sv/xsr_pkg.sv =====
// Package with the operation codes, sequencer states and constants of the xorshift32 generator.
package xsr_pkg;

    typedef enum logic [1:0] {
        OP_RESEED   = 2'd0,
        OP_RAW      = 2'd1,
        OP_RANGE    = 2'd2,
        OP_FRACTION = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX_A,
        ST_MIX_B,
        ST_MIX_C,
        ST_ADVANCE,
        ST_MULTIPLY,
        ST_FINISH
    } state_t;

    localparam logic [31:0] GOLDEN_ADD = 32'h9E37_79B9;
    localparam logic [31:0] MIX_MUL_A  = 32'h85EB_CA6B;
    localparam logic [31:0] MIX_MUL_B  = 32'hC2B2_AE35;

    localparam int unsigned SHIFT_A = 13;
    localparam int unsigned SHIFT_B = 17;
    localparam int unsigned SHIFT_C = 5;
    localparam int unsigned FRACTION_SHIFT = 8;

    // Evaluated only on constants, to give the state after reset.
    function automatic logic [31:0] mix_seed(input logic [31:0] seed);
        logic [31:0] s;
        logic [63:0] p;
        s = seed + GOLDEN_ADD;
        s = s ^ (s >> 16);
        p = {32'd0, s} * {32'd0, MIX_MUL_A};
        s = p[31:0];
        s = s ^ (s >> 13);
        p = {32'd0, s} * {32'd0, MIX_MUL_B};
        s = p[31:0];
        s = s ^ (s >> 16);
        return s;
    endfunction

    localparam logic [31:0] RESET_STATE = mix_seed(32'd0);

    function automatic logic [31:0] xorshift(input logic [31:0] w);
        logic [31:0] x;
        x = w ^ (w << SHIFT_A);
        x = x ^ (x >> SHIFT_B);
        x = x ^ (x << SHIFT_C);
        return x;
    endfunction

endpackage

// ===== sv/xorshift32_random_with_range.sv =====
// Top level of the xorshift32 generator with reseed, raw, range and fraction operations.
//
//  Channel | Ports                                                  | Direction
//  --------+--------------------------------------------------------+----------
//  s_      | s_valid s_ready s_operation s_seed s_min_value s_max_value | in
//  m_      | m_valid m_ready m_value                                | out
//
// One transaction at a time goes through a small sequencer around one shared
// 32x32 multiplier. Reseed runs three mixing steps after the accept; raw and
// fraction run advance and finish, range runs advance, multiply-high and add.
// The result waits in an output register; a new transaction is accepted while
// it waits, and the sequencer stalls in its last step only if the register is full.
// Reset is synchronous and active low and loads the state with the mix of seed zero.
module xorshift32_random_with_range (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_operation,
    input  logic [31:0]         s_seed,
    input  logic signed [31:0]  s_min_value,
    input  logic signed [31:0]  s_max_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [31:0]         m_value
);
    import xsr_pkg::*;

    state_t      state_reg, state_next;
    op_t         op_reg, op_next;
    logic [31:0] gen_reg, gen_next;
    logic [31:0] work_reg, work_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] span_reg, span_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_value_reg, m_value_next;

    logic        accept;
    logic        out_free;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] product;
    logic [31:0] result;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign product  = {32'd0, mul_x} * {32'd0, mul_y};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (op_t'(s_operation) == OP_RESEED) begin
                        state_next = ST_MIX_A;
                    end else begin
                        state_next = ST_ADVANCE;
                    end
                end
            end
            ST_MIX_A:    state_next = ST_MIX_B;
            ST_MIX_B:    state_next = ST_MIX_C;
            ST_MIX_C:    state_next = ST_IDLE;
            ST_ADVANCE: begin
                if (op_reg == OP_RANGE) begin
                    state_next = ST_MULTIPLY;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_MULTIPLY: state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        op_next      = op_reg;
        gen_next     = gen_reg;
        work_next    = work_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        span_next    = span_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        mul_x        = work_reg;
        mul_y        = span_reg;
        result       = work_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next   = op_t'(s_operation);
                    work_next = s_seed + GOLDEN_ADD;
                    if (s_min_value > s_max_value) begin
                        lo_next = s_max_value;
                        hi_next = s_min_value;
                    end else begin
                        lo_next = s_min_value;
                        hi_next = s_max_value;
                    end
                end
            end
            ST_MIX_A: begin
                mul_x     = work_reg ^ (work_reg >> 16);
                mul_y     = MIX_MUL_A;
                work_next = product[31:0];
            end
            ST_MIX_B: begin
                mul_x     = work_reg ^ (work_reg >> 13);
                mul_y     = MIX_MUL_B;
                work_next = product[31:0];
            end
            ST_MIX_C: begin
                gen_next = work_reg ^ (work_reg >> 16);
            end
            ST_ADVANCE: begin
                gen_next  = xorshift(gen_reg);
                work_next = xorshift(gen_reg);
                span_next = hi_reg - lo_reg + 32'd1;
            end
            ST_MULTIPLY: begin
                // A zero span stands for the full 2^32 range: the word passes through.
                if (span_reg != 32'd0) begin
                    work_next = product[63:32];
                end
            end
            ST_FINISH: begin
                case (op_reg)
                    OP_FRACTION: result = work_reg >> FRACTION_SHIFT;
                    OP_RANGE: begin
                        if (span_reg != 32'd0) begin
                            result = lo_reg + work_reg;
                        end
                    end
                    default:     result = work_reg;
                endcase
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = result;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gen_reg     <= RESET_STATE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gen_reg     <= gen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        work_reg    <= work_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        span_reg    <= span_next;
        m_value_reg <= m_value_next;
    end

endmodule

// ===== sv/xsr_checker.sv =====
// Port-level assertion checker for the xorshift32 generator and its bind statement.
module xsr_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [1:0]          s_operation,
    input logic                m_valid,
    input logic                m_ready,
    input logic [31:0]         m_value
);
    import xsr_pkg::*;

    // The output register is empty right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // A waiting result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value))
        else $error("stalled result changed");

    // Once a transaction is accepted, s_ready drops and the block is busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a transaction while busy");

    // No result can appear in the cycle after an accept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared too early");

    // A reseed accepted while no result waits produces no result during ST_MIX_A and ST_MIX_B.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (op_t'(s_operation) == OP_RESEED) && !m_valid
        |=> !m_valid ##1 !m_valid)
        else $error("reseed produced a result");

endmodule

bind xorshift32_random_with_range xsr_checker u_xsr_checker (.*);

// ===== tb/sv/tb_xorshift32_random_with_range.sv =====
// Self-checking testbench for the xorshift32 generator with range and fraction operations.
module tb_xorshift32_random_with_range;
    timeunit 1ns;
    timeprecision 1ps;

    import xsr_pkg::*;

    localparam int CLOCK_HALF_NS = 5;
    localparam int RANDOM_ITEMS = 1825;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 16;
    localparam int TIMEOUT_NS = 5_000_000;
    localparam int DIRECTED_COUNT = 25;

    localparam logic signed [31:0] BOUND_LOW = 32'sh8000_0000;
    localparam logic signed [31:0] BOUND_HIGH = 32'sh7FFF_FFFF;
    localparam logic [31:0] ZERO_STATE_SEED = 32'd0 - GOLDEN_ADD;

    typedef struct packed {
        op_t op;
        logic [31:0] seed;
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
        logic typed;
        logic [31:0] value;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [1:0] s_operation;
    logic [31:0] s_seed;
    logic signed [31:0] s_min_value;
    logic signed [31:0] s_max_value;
    logic m_valid;
    logic m_ready;
    logic [31:0] m_value;

    logic [31:0] gen_state;
    logic [31:0] pending_values[$];
    int fail_count = 0;
    int results_checked = 0;
    int op_count[4] = '{0, 0, 0, 0};
    int hold_asked = 0;

    stim_row_t directed_rows[DIRECTED_COUNT] = '{
        '{OP_RAW,      32'h0000_0000, 32'sd0,      32'sd0,      1'b0, 32'h0},
        '{OP_RANGE,    32'hFFFF_FFFF, 32'sd7,      32'sd7,      1'b1, 32'd7},
        '{OP_RANGE,    32'h0000_0000, BOUND_LOW,   BOUND_LOW,   1'b1, 32'h8000_0000},
        '{OP_RANGE,    32'h0000_0000, BOUND_HIGH,  BOUND_HIGH,  1'b1, 32'h7FFF_FFFF},
        '{OP_RANGE,    32'h0000_0000, BOUND_LOW,   BOUND_HIGH,  1'b0, 32'h0},
        '{OP_RANGE,    32'h0000_0000, BOUND_HIGH,  BOUND_LOW,   1'b0, 32'h0},
        '{OP_RANGE,    32'h0000_0000, 32'sd100,    -32'sd100,   1'b0, 32'h0},
        '{OP_RANGE,    32'h0000_0000, -32'sd1,     32'sd0,      1'b0, 32'h0},
        '{OP_FRACTION, 32'hFFFF_FFFF, BOUND_HIGH,  BOUND_LOW,   1'b0, 32'h0},
        '{OP_RESEED,   32'h0000_0000, 32'sd0,      32'sd0,      1'b0, 32'h0},
        '{OP_RAW,      32'h0000_0000, 32'sd0,      32'sd0,      1'b0, 32'h0},
        '{OP_RESEED,   32'hFFFF_FFFF, BOUND_LOW,   BOUND_HIGH,  1'b0, 32'h0},
        '{OP_FRACTION, 32'h0000_0000, 32'sd0,      32'sd0,      1'b0, 32'h0},
        '{OP_RANGE,    32'h0000_0000, BOUND_LOW,   32'sd0,      1'b0, 32'h0},
        '{OP_RANGE,    32'h0000_0000, 32'sd0,      BOUND_HIGH,  1'b0, 32'h0},
        '{OP_RESEED,   ZERO_STATE_SEED, 32'sd0,    32'sd0,      1'b0, 32'h0},
        '{OP_RAW,      32'hFFFF_FFFF, 32'sd0,      32'sd0,      1'b1, 32'h0},
        '{OP_FRACTION, 32'h0000_0000, 32'sd0,      32'sd0,      1'b1, 32'h0},
        '{OP_RANGE,    32'h0000_0000, 32'sd5,      32'sd100,    1'b1, 32'd5},
        '{OP_RANGE,    32'h0000_0000, 32'sd100,    32'sd5,      1'b1, 32'd5},
        '{OP_RANGE,    32'h0000_0000, BOUND_LOW,   BOUND_HIGH,  1'b1, 32'h0},
        '{OP_RANGE,    32'h0000_0000, BOUND_LOW,   -32'sd2147483638, 1'b1, 32'h8000_0000},
        '{OP_RESEED,   32'h1234_5678, 32'sd0,      32'sd0,      1'b0, 32'h0},
        '{OP_RAW,      32'h0000_0000, 32'sd0,      32'sd0,      1'b0, 32'h0},
        '{OP_RANGE,    32'h0000_0000, BOUND_LOW + 32'sd1, BOUND_HIGH, 1'b0, 32'h0}
    };

    xorshift32_random_with_range DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_seed      (s_seed),
        .s_min_value (s_min_value),
        .s_max_value (s_max_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value)
    );

    always #CLOCK_HALF_NS aclk = ~aclk;

    function automatic logic [31:0] avalanche(input logic [31:0] seed);
        logic [31:0] h;
        h = seed + GOLDEN_ADD;
        h = h ^ (h >> 16);
        h = h * MIX_MUL_A;
        h = h ^ (h >> 13);
        h = h * MIX_MUL_B;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic logic [31:0] step_generator();
        logic [31:0] w;
        w = gen_state;
        w = w ^ (w << SHIFT_A);
        w = w ^ (w >> SHIFT_B);
        w = w ^ (w << SHIFT_C);
        gen_state = w;
        return w;
    endfunction

    // Updates the generator copy and returns the value the transaction should produce.
    function automatic logic [31:0] predict_value(input op_t op, input logic [31:0] seed,
                                                  input logic signed [31:0] min_value,
                                                  input logic signed [31:0] max_value);
        logic signed [31:0] low_b;
        logic signed [31:0] high_b;
        logic [31:0] span;
        logic [31:0] word;
        logic [63:0] product;
        logic [31:0] result;
        result = 32'd0;
        case (op)
            OP_RESEED: begin
                gen_state = avalanche(seed);
            end
            OP_RAW: begin
                result = step_generator();
            end
            OP_RANGE: begin
                low_b = (min_value > max_value) ? max_value : min_value;
                high_b = (min_value > max_value) ? min_value : max_value;
                span = 32'(high_b - low_b) + 32'd1;
                word = step_generator();
                if (span == 32'd0) begin
                    result = word;
                end else begin
                    product = 64'(word) * 64'(span);
                    result = 32'(low_b) + product[63:32];
                end
            end
            default: begin
                result = step_generator() >> FRACTION_SHIFT;
            end
        endcase
        return result;
    endfunction

    task automatic offer(input op_t op, input logic [31:0] seed,
                         input logic signed [31:0] min_value,
                         input logic signed [31:0] max_value,
                         input logic typed, input logic [31:0] value);
        logic [31:0] predicted;
        s_valid <= 1'b1;
        s_operation <= op;
        s_seed <= seed;
        s_min_value <= min_value;
        s_max_value <= max_value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = predict_value(op, seed, min_value, max_value);
        op_count[int'(op)]++;
        if (op != OP_RESEED) begin
            pending_values.push_back(typed ? value : predicted);
        end
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_values.size() != 0);
    endtask

    function automatic logic signed [31:0] pick_bound();
        logic signed [31:0] b;
        case ($urandom_range(0, 7))
            0, 1, 2: b = $urandom;
            3: b = $signed($urandom_range(0, 200)) - 32'sd100;
            4: b = BOUND_LOW + $signed($urandom_range(0, 3));
            5: b = BOUND_HIGH - $signed($urandom_range(0, 3));
            6: b = $signed($urandom_range(0, 65535));
            default: b = -$signed($urandom_range(0, 65535));
        endcase
        return b;
    endfunction

    task automatic offer_random();
        op_t op;
        logic [31:0] seed;
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
        int pick;
        pick = $urandom_range(0, 99);
        op = (pick < 10) ? OP_RESEED : (pick < 35) ? OP_RAW : (pick < 80) ? OP_RANGE : OP_FRACTION;
        seed = $urandom;
        if (op == OP_RESEED && $urandom_range(0, 31) == 0) begin
            seed = ZERO_STATE_SEED;
        end
        min_value = $urandom;
        max_value = $urandom;
        if (op == OP_RANGE) begin
            case ($urandom_range(0, 9))
                0: begin
                    min_value = BOUND_LOW;
                    max_value = BOUND_HIGH;
                end
                1: begin
                    min_value = BOUND_HIGH;
                    max_value = BOUND_LOW;
                end
                2: begin
                    min_value = pick_bound();
                    max_value = min_value;
                end
                3, 4: begin
                    min_value = pick_bound();
                    max_value = min_value + $signed($urandom_range(1, 50));
                end
                default: begin
                    min_value = pick_bound();
                    max_value = pick_bound();
                end
            endcase
        end
        offer(op, seed, min_value, max_value, 1'b0, 32'h0);
    endtask

    initial begin : stimulus
        int burst_left;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = OP_RESEED;
        s_seed = 32'd0;
        s_min_value = 32'sd0;
        s_max_value = 32'sd0;
        gen_state = avalanche(32'd0);
        burst_left = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            offer(directed_rows[i].op, directed_rows[i].seed, directed_rows[i].min_value,
                  directed_rows[i].max_value, directed_rows[i].typed, directed_rows[i].value);
            pause_sender($urandom_range(0, 2));
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 400 || n == 1200) begin
                // The receiver stops for a long stretch while items keep coming.
                hold_asked++;
                burst_left = 80;
            end
            if (n == 800 || n == 1500) begin
                wait_for_results();
            end
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
                pause_sender($urandom_range(0, 6));
            end
            burst_left--;
            offer_random();
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Run covered %0d reseed, %0d raw, %0d range and %0d fraction transactions;",
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("%0d results were checked, %0d mismatches found.", results_checked, fail_count);
        if (fail_count == 0) begin
            $display("PASS xorshift32_random_with_range");
        end else begin
            $display("FAIL xorshift32_random_with_range");
        end
        $finish;
    end

    initial begin : receiver
        int mode_left;
        int stall_pct;
        int hold_served;
        m_ready = 1'b0;
        mode_left = 0;
        stall_pct = 0;
        hold_served = 0;
        @(posedge aclk);
        forever begin
            if (hold_served != hold_asked) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                hold_served++;
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(16, 96);
                    case ($urandom_range(0, 2))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        default: stall_pct = 70;
                    endcase
                end
                mode_left--;
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        logic [31:0] value;
        if (aresetn && m_valid && m_ready) begin
            if (pending_values.size() == 0) begin
                $error("m_value: no transaction expected, actual %h", m_value);
                fail_count++;
            end else begin
                value = pending_values.pop_front();
                results_checked++;
                if (m_value !== value) begin
                    $error("m_value: expected %h, actual %h", value, m_value);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("FAIL xorshift32_random_with_range");
        $finish;
    end

endmodule

// ===== files.f =====
sv/xsr_pkg.sv
sv/xorshift32_random_with_range.sv
sv/xsr_checker.sv
tb/sv/tb_xorshift32_random_with_range.sv
